FILE: hdl/flea_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package flea_pkg;

  localparam int unsigned DataW = 32;

  localparam logic [DataW-1:0] ResetV = 32'd314159;
  localparam logic [DataW-1:0] ResetW = 32'd265358;
  localparam logic [DataW-1:0] ResetX = 32'd932384;
  localparam logic [DataW-1:0] ResetY = 32'd643383;
  localparam logic [DataW-1:0] ResetZ = 32'd279502;

  localparam logic [DataW-1:0] WarmupSpan = 32'd1000;
  localparam logic [10:0]      WarmupBase = 11'd1000;

  // Request modes as carried on the input stream's tuser.
  typedef enum logic [2:0] {
    ModeReseed = 3'd0,
    ModeRaw    = 3'd1,
    ModeModulo = 3'd2,
    ModeMask   = 3'd3,
    ModeChance = 3'd4,
    ModePair   = 3'd5,
    ModeSpare6 = 3'd6,
    ModeSpare7 = 3'd7
  } mode_e;

  // Seed register indexes on the config channel.
  typedef enum logic {
    RegSeedFirst  = 1'b0,
    RegSeedSecond = 1'b1
  } seed_reg_e;

  typedef struct packed {
    logic [DataW-1:0] v;
    logic [DataW-1:0] w;
    logic [DataW-1:0] x;
    logic [DataW-1:0] y;
    logic [DataW-1:0] z;
  } words_t;

  // One generator step; the new y is the yielded word.
  function automatic words_t flea_advance(input words_t s);
    words_t n;
    n.v = s.w;
    n.w = s.x;
    n.x = {s.y[12:0], s.y[31:13]} + s.z;
    n.y = s.z ^ n.w;
    n.z = n.v + n.x;
    return n;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/flea_prng_32_with_ranges.sv
`timescale 1ns / 1ps
`default_nettype none

// Five-word 32-bit pseudo-random generator with range helpers.
// Input stream: s_axis_tuser carries the mode, s_axis_tdata the operands.
// Modes: reseed, raw word, word mod limit, masked word, masked chance
// against a threshold, and a pair of distinct values below a limit.
// Output stream: one result transfer per input transfer, in order.
// Config channel: cfg_index_i 0 writes seed_first, 1 writes seed_second;
// always ready, write only while the block is idle.
// Throughput: one item at a time; s_axis_tready is high only in the
// idle state. Raw, mask and chance take one generator step; modulo uses
// the shared one-bit-per-cycle remainder unit once and pair twice
// (32 iterations per division). Reseed divides the seed sum by 1000, then
// runs 1000 to 1999 warm-up steps, one generator step per cycle.
// Reset loads the fixed starting words and clears both seeds; no item is
// pending. A stalled receiver holds the result in the output register;
// the next item may be taken meanwhile, but its result waits until the
// output register is free.
module flea_prng_32_with_ranges (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // Input stream
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [95:0]  s_axis_tdata,  // limit[30:0], bit_mask[62:31],
                                           // threshold[93:63], zeros
  input  wire logic [2:0]   s_axis_tuser,  // mode[2:0]
  // Output stream
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [71:0]       m_axis_tdata,  // first_value[31:0],
                                           // second_value[62:32], hit[63],
                                           // bad_operand[64], zeros
  // Config write channel
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic         cfg_index_i,
  input  wire logic [31:0]  cfg_data_i
);
  import flea_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StPair2,
    StSeedDiv,
    StWarm,
    StDiv1,
    StDiv2,
    StDone
  } state_e;

  // Input fields
  logic [30:0] limit;
  logic [31:0] bit_mask;
  logic [30:0] threshold;
  mode_e       mode;

  assign limit     = s_axis_tdata[30:0];
  assign bit_mask  = s_axis_tdata[62:31];
  assign threshold = s_axis_tdata[93:63];
  assign mode      = mode_e'(s_axis_tuser);

  // Seed registers
  logic [31:0] seed_first_q;
  logic [31:0] seed_second_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_first_q  <= '0;
      seed_second_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegSeedFirst:  seed_first_q  <= cfg_data_i;
        RegSeedSecond: seed_second_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer state
  state_e      state_q;
  words_t      words_q;
  mode_e       mode_q;
  logic [30:0] limit_q;
  logic [31:0] r2_q;
  logic [31:0] first_q;
  logic [30:0] second_q;
  logic        hit_q;
  logic        bad_q;
  logic [10:0] warmup_count_q;
  logic [10:0] cnt_q;
  logic        div_start_q;
  logic [31:0] div_a_q;
  logic [31:0] div_b_q;
  logic        m_valid_q;
  logic [71:0] m_data_q;

  // Shared generator step and remainder unit
  words_t      adv;
  logic        div_done;
  logic [31:0] div_rem;
  logic [31:0] masked;
  logic [31:0] pair_sum;
  logic [31:0] pair_wrap;
  logic [10:0] cnt_d;

  always_comb begin
    adv       = flea_advance(words_q);
    masked    = adv.y & bit_mask;
    pair_sum  = first_q + div_rem + 32'd1;
    pair_wrap = (pair_sum >= {1'b0, limit_q}) ? pair_sum - {1'b0, limit_q} : pair_sum;
    cnt_d     = cnt_q + 11'd1;
  end

  flea_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (div_a_q),
    .divisor_i  (div_b_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  assign s_axis_tready = (state_q == StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      words_q        <= '{v: ResetV, w: ResetW, x: ResetX, y: ResetY, z: ResetZ};
      mode_q         <= ModeRaw;
      limit_q        <= '0;
      r2_q           <= '0;
      first_q        <= '0;
      second_q       <= '0;
      hit_q          <= 1'b0;
      bad_q          <= 1'b0;
      warmup_count_q <= '0;
      cnt_q          <= '0;
      div_start_q    <= 1'b0;
      div_a_q        <= '0;
      div_b_q        <= '0;
      m_valid_q      <= 1'b0;
      m_data_q       <= '0;
    end else begin
      div_start_q <= 1'b0;
      // Drop the result once the receiver takes it
      if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      case (state_q)
        StIdle: begin
          if (s_axis_tvalid) begin
            mode_q   <= mode;
            limit_q  <= limit;
            first_q  <= '0;
            second_q <= '0;
            hit_q    <= 1'b0;
            bad_q    <= 1'b0;
            state_q  <= StDone;
            case (mode)
              ModeReseed: begin
                // Reload, add seeds, then size the warm-up by the seed sum
                words_q     <= '{v: ResetV, w: ResetW, x: ResetX + seed_second_q,
                                 y: ResetY, z: ResetZ + seed_first_q};
                div_start_q <= 1'b1;
                div_a_q     <= seed_first_q + seed_second_q;
                div_b_q     <= WarmupSpan;
                state_q     <= StSeedDiv;
              end
              ModeRaw: begin
                words_q <= adv;
                first_q <= adv.y;
              end
              ModeModulo: begin
                words_q <= adv;
                if (limit == '0) begin
                  bad_q <= 1'b1;
                end else begin
                  div_start_q <= 1'b1;
                  div_a_q     <= adv.y;
                  div_b_q     <= {1'b0, limit};
                  state_q     <= StDiv1;
                end
              end
              ModeMask: begin
                words_q <= adv;
                first_q <= masked;
              end
              ModeChance: begin
                words_q <= adv;
                first_q <= masked;
                hit_q   <= (masked < {1'b0, threshold});
              end
              ModePair: begin
                // Hold the first word; take the second step next cycle
                words_q <= adv;
                first_q <= adv.y;
                state_q <= StPair2;
              end
              default: ;
            endcase
          end
        end

        StPair2: begin
          words_q <= adv;
          r2_q    <= adv.y;
          if (limit_q < 31'd2) begin
            first_q <= '0;
            bad_q   <= 1'b1;
            state_q <= StDone;
          end else begin
            div_start_q <= 1'b1;
            div_a_q     <= first_q;
            div_b_q     <= {1'b0, limit_q};
            state_q     <= StDiv1;
          end
        end

        StSeedDiv: begin
          if (div_done) begin
            warmup_count_q <= {1'b0, div_rem[9:0]} + WarmupBase;
            cnt_q          <= '0;
            state_q        <= StWarm;
          end
        end

        StWarm: begin
          // Advance once per cycle until the warm-up count is reached
          words_q <= adv;
          cnt_q   <= cnt_d;
          if (cnt_d == warmup_count_q) begin
            state_q <= StDone;
          end
        end

        StDiv1: begin
          if (div_done) begin
            first_q <= div_rem;
            if (mode_q == ModePair) begin
              div_start_q <= 1'b1;
              div_a_q     <= r2_q;
              div_b_q     <= {1'b0, limit_q - 31'd1};
              state_q     <= StDiv2;
            end else begin
              state_q <= StDone;
            end
          end
        end

        StDiv2: begin
          if (div_done) begin
            second_q <= pair_wrap[30:0];
            state_q  <= StDone;
          end
        end

        StDone: begin
          // Hold the result until the output register is free
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {7'b0, bad_q, hit_q, second_q, first_q};
            state_q   <= StIdle;
          end
        end

        default: state_q <= StIdle;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

`default_nettype wire

FILE: hdl/flea_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring remainder unit, one quotient bit per cycle.
module flea_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [flea_pkg::DataW-1:0]  dividend_i,
  input  wire logic [flea_pkg::DataW-1:0]  divisor_i,
  output logic                             done_o,
  output logic [flea_pkg::DataW-1:0]       rem_o
);
  import flea_pkg::*;

  localparam int unsigned CntW = $clog2(DataW);

  logic              busy_q;
  logic [CntW-1:0]   cnt_q;
  logic [DataW-1:0]  dvd_q;
  logic [DataW-1:0]  dsr_q;
  logic [DataW-1:0]  rem_q;
  logic              done_q;

  logic [DataW:0]    rem_sh;
  logic [DataW:0]    diff;
  logic [DataW-1:0]  rem_d;

  always_comb begin
    rem_sh = {rem_q, dvd_q[DataW-1]};
    diff   = rem_sh - {1'b0, dsr_q};
    rem_d  = diff[DataW] ? rem_sh[DataW-1:0] : diff[DataW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      dvd_q  <= '0;
      dsr_q  <= '0;
      rem_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
      dvd_q  <= dividend_i;
      dsr_q  <= divisor_i;
      rem_q  <= '0;
      done_q <= 1'b0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[DataW-2:0], 1'b0};
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CntW'(DataW - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire
